[design/sfps_pkg.sv]
// Package for the sprite frame and path sequencer.
// Op codes, configuration register indexes, field widths and the
// interpolation request type. No dependencies.
`default_nettype none

package sfps_pkg;

  localparam int unsigned CoordW    = 16;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned CountW    = 5;
  localparam int unsigned FrameW    = 4;
  localparam int unsigned OpW       = 3;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // frame_count above this value acts as this value
  localparam logic [CountW-1:0] MaxFrames = 5'd16;

  typedef enum logic [OpW-1:0] {
    OpTick        = 3'd0,
    OpStart       = 3'd1,
    OpPause       = 3'd2,
    OpStop        = 3'd3,
    OpAddPoint    = 3'd4,
    OpClearPoints = 3'd5
  } op_e;

  localparam logic [CfgIdxW-1:0] CfgFrameInterval = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTrackInterval = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFrameCount    = 2'd2;

  typedef struct packed {
    logic signed [CoordW-1:0] base;
    logic signed [CoordW-1:0] next;
    logic [IntervalW-1:0]     elapsed;
    logic [IntervalW-1:0]     interval;
  } lerp_req_t;

endpackage

`default_nettype wire

[design/sfps_intf.sv]
// Channel interfaces of the sprite frame and path sequencer:
// input items, result items and configuration writes.
// Depends on sfps_pkg.
`default_nettype none

interface sfps_in_if import sfps_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OpW-1:0]           op;
  logic [TimeW-1:0]         now_ms;
  logic signed [CoordW-1:0] point_x;
  logic signed [CoordW-1:0] point_y;

  modport source (output valid, op, now_ms, point_x, point_y, input ready);
  modport sink   (input valid, op, now_ms, point_x, point_y, output ready);
endinterface

interface sfps_out_if import sfps_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     active;
  logic [FrameW-1:0]        frame_index;
  logic                     on_path;
  logic signed [CoordW-1:0] pos_x;
  logic signed [CoordW-1:0] pos_y;
  logic                     dropped;

  modport source (output valid, active, frame_index, on_path, pos_x, pos_y, dropped,
                  input ready);
  modport sink   (input valid, active, frame_index, on_path, pos_x, pos_y, dropped,
                  output ready);
endinterface

interface sfps_cfg_if import sfps_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/sfps_lerp.sv]
// Bit-serial linear interpolation for one axis:
// pos = trunc((base*t + (next-base)*e) / t), 16-step shift-add multiply
// then 16-step restoring divide. Depends on sfps_pkg.
`default_nettype none

module sfps_lerp import sfps_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  lerp_req_t                req_i,
  output logic                     done_o,
  output logic signed [CoordW-1:0] pos_o
);

  localparam int unsigned AccW = 35;

  typedef enum logic [2:0] {L_IDLE, L_MUL, L_ABS, L_DIV, L_FIN} lstate_e;

  lstate_e                    state_q;
  logic [3:0]                 cnt_q;
  logic signed [CoordW-1:0]   base_q;
  logic signed [CoordW:0]     diff_q;
  logic [IntervalW-1:0]       e_sh_q;
  logic [IntervalW-1:0]       t_sh_q;
  logic [IntervalW-1:0]       t_q;
  logic signed [AccW-1:0]     acc_q;
  logic                       neg_q;
  logic [IntervalW-1:0]       rem_q;
  logic [IntervalW-1:0]       quo_q;
  logic signed [CoordW-1:0]   pos_q;
  logic                       done_q;

  logic signed [AccW-1:0]     add_t, add_e, acc_d;
  logic signed [AccW-1:0]     mag;
  logic [IntervalW:0]         trial;
  logic                       fits;
  logic [IntervalW-1:0]       rem_d;
  logic [IntervalW-1:0]       signed_quo;

  always_comb begin
    // MSB first: acc = 2*acc + t_bit*base + e_bit*diff
    add_t = t_sh_q[IntervalW-1] ? AccW'(base_q) : '0;
    add_e = e_sh_q[IntervalW-1] ? AccW'(diff_q) : '0;
    acc_d = (acc_q <<< 1) + add_t + add_e;
    mag   = acc_q[AccW-1] ? -acc_q : acc_q;
    trial = {rem_q, quo_q[IntervalW-1]};
    fits  = trial >= {1'b0, t_q};
    rem_d = fits ? IntervalW'(trial - {1'b0, t_q}) : trial[IntervalW-1:0];
    signed_quo = neg_q ? IntervalW'(-quo_q) : quo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      cnt_q   <= '0;
      base_q  <= '0;
      diff_q  <= '0;
      e_sh_q  <= '0;
      t_sh_q  <= '0;
      t_q     <= '0;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      rem_q   <= '0;
      quo_q   <= '0;
      pos_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == L_FIN) ||
                ((state_q == L_IDLE) && start_i && (req_i.interval == '0));
      unique case (state_q)
        L_IDLE: begin
          if (start_i) begin
            if (req_i.interval == '0) begin
              pos_q <= req_i.base;
            end else begin
              base_q  <= req_i.base;
              diff_q  <= (CoordW+1)'(req_i.next) - (CoordW+1)'(req_i.base);
              e_sh_q  <= req_i.elapsed;
              t_sh_q  <= req_i.interval;
              t_q     <= req_i.interval;
              acc_q   <= '0;
              cnt_q   <= 4'd15;
              state_q <= L_MUL;
            end
          end
        end
        L_MUL: begin
          acc_q  <= acc_d;
          e_sh_q <= {e_sh_q[IntervalW-2:0], 1'b0};
          t_sh_q <= {t_sh_q[IntervalW-2:0], 1'b0};
          cnt_q  <= cnt_q - 4'd1;
          if (cnt_q == '0) state_q <= L_ABS;
        end
        L_ABS: begin
          // |num| <= 32768*t, so the upper half is already below t
          neg_q   <= acc_q[AccW-1];
          rem_q   <= mag[31:16];
          quo_q   <= mag[15:0];
          cnt_q   <= 4'd15;
          state_q <= L_DIV;
        end
        L_DIV: begin
          rem_q <= rem_d;
          quo_q <= {quo_q[IntervalW-2:0], fits};
          cnt_q <= cnt_q - 4'd1;
          if (cnt_q == '0) state_q <= L_FIN;
        end
        L_FIN: begin
          // result lies between the two waypoints, no saturation needed
          pos_q   <= signed_quo;
          state_q <= L_IDLE;
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign pos_o  = pos_q;

endmodule

`default_nettype wire

[design/sprite_frame_and_path_sequencer_core.sv]
// Sprite frame and path sequencer, top level. Depends on sfps_pkg, sfps_intf, sfps_lerp.
// One item at a time. Non-tick ops and ticks without a path go from S_EXEC to S_OUT, which
// loads the output register; an interpolated tick reads the waypoints in S_RDA to S_RDC and
// waits in S_LERP for the bit-serial multiply and restoring divide in sfps_lerp (x and y run
// side by side; a zero track interval skips both). After the load the block returns to S_IDLE
// for the next input transfer; a stalled result holds off the input.
// Reset clears all control state; the waypoint table is undefined and read only below the count.
`default_nettype none

module sprite_frame_and_path_sequencer_core import sfps_pkg::*; #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfps_cfg_if.sink   cfg_i,
  sfps_in_if.sink    in_i,
  sfps_out_if.source out_o
);

  localparam int unsigned PW = $clog2(MAX_POINTS);
  localparam int unsigned TW = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_RDA, S_RDB, S_RDC, S_LERP, S_OUT} state_e;

  state_e                   state_q;

  logic [IntervalW-1:0]     frame_interval_q;
  logic [IntervalW-1:0]     track_interval_q;
  logic [CountW-1:0]        frame_count_q;

  logic                     running_q;
  logic [FrameW-1:0]        cur_frame_q;
  logic [TimeW-1:0]         frame_since_q;
  logic [PW-1:0]            cur_point_q;
  logic [TimeW-1:0]         point_since_q;
  logic [TW-1:0]            point_total_q;

  logic [OpW-1:0]           op_q;
  logic [TimeW-1:0]         now_q;
  logic signed [CoordW-1:0] px_q;
  logic signed [CoordW-1:0] py_q;

  logic [PW-1:0]            nxt_q;
  logic [IntervalW-1:0]     e_q;
  logic [31:0]              a_q;

  logic                     res_active_q;
  logic [FrameW-1:0]        res_frame_q;
  logic                     res_on_path_q;
  logic                     res_dropped_q;

  logic                     out_valid_q;
  logic                     out_active_q;
  logic [FrameW-1:0]        out_frame_q;
  logic                     out_on_path_q;
  logic signed [CoordW-1:0] out_pos_x_q;
  logic signed [CoordW-1:0] out_pos_y_q;
  logic                     out_dropped_q;

  logic [31:0]              mem_q [MAX_POINTS];
  logic [31:0]              rdata_q;
  logic [PW-1:0]            rd_addr;
  logic                     rd_en;

  // tick datapath, evaluated in S_EXEC
  logic [CountW-1:0]        fc;
  logic                     tick_live;
  logic                     path_live;
  logic [FrameW-1:0]        cf_base, cf_inc, cf_new;
  logic                     frame_due;
  logic [PW-1:0]            cp_base, cp_inc, cp_new, cp_nxt;
  logic [TimeW-1:0]         point_elapsed;
  logic                     point_due;
  logic [IntervalW-1:0]     e_new;
  logic                     table_full;
  logic                     out_load;

  lerp_req_t                req_x, req_y;
  logic                     lerp_start;
  logic                     done_x, done_y;
  logic signed [CoordW-1:0] pos_x, pos_y;

  always_comb begin
    fc        = (frame_count_q > MaxFrames) ? MaxFrames : frame_count_q;
    tick_live = running_q && (fc != '0);
    path_live = (op_q == OpTick) && tick_live && (point_total_q > TW'(1));
    cf_base   = ({1'b0, cur_frame_q} >= fc) ? '0 : cur_frame_q;
    frame_due = (fc > CountW'(1)) &&
                ((now_q - frame_since_q) >= {{(TimeW-IntervalW){1'b0}}, frame_interval_q});
    cf_inc    = (({1'b0, cf_base} + CountW'(1)) == fc) ? '0 : cf_base + FrameW'(1);
    cf_new    = frame_due ? cf_inc : cf_base;

    cp_base       = (TW'(cur_point_q) >= point_total_q) ? '0 : cur_point_q;
    point_elapsed = now_q - point_since_q;
    point_due     = point_elapsed >= {{(TimeW-IntervalW){1'b0}}, track_interval_q};
    cp_inc        = ((TW'(cp_base) + TW'(1)) == point_total_q) ? '0
                                                               : PW'(TW'(cp_base) + TW'(1));
    cp_new        = point_due ? cp_inc : cp_base;
    cp_nxt        = ((TW'(cp_new) + TW'(1)) == point_total_q) ? '0
                                                              : PW'(TW'(cp_new) + TW'(1));
    // after a step the elapsed time restarts; otherwise it stays below the track interval
    e_new         = point_due ? '0 : point_elapsed[IntervalW-1:0];

    table_full = point_total_q >= TW'(MAX_POINTS);
    out_load   = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

    rd_en   = (state_q == S_RDA) || (state_q == S_RDB);
    rd_addr = (state_q == S_RDA) ? cur_point_q : nxt_q;

    lerp_start     = (state_q == S_RDC);
    req_x.base     = a_q[15:0];
    req_x.next     = rdata_q[15:0];
    req_x.elapsed  = e_q;
    req_x.interval = track_interval_q;
    req_y.base     = a_q[31:16];
    req_y.next     = rdata_q[31:16];
    req_y.elapsed  = e_q;
    req_y.interval = track_interval_q;
  end

  sfps_lerp u_lerp_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lerp_start),
    .req_i   (req_x),
    .done_o  (done_x),
    .pos_o   (pos_x)
  );

  sfps_lerp u_lerp_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lerp_start),
    .req_i   (req_y),
    .done_o  (done_y),
    .pos_o   (pos_y)
  );

  // waypoint table: x in the low half, y in the high half
  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC && op_q == OpAddPoint && !table_full) begin
      mem_q[point_total_q[PW-1:0]] <= {py_q, px_q};
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      frame_interval_q <= '0;
      track_interval_q <= '0;
      frame_count_q    <= '0;
      running_q        <= 1'b0;
      cur_frame_q      <= '0;
      frame_since_q    <= '0;
      cur_point_q      <= '0;
      point_since_q    <= '0;
      point_total_q    <= '0;
      op_q             <= '0;
      now_q            <= '0;
      px_q             <= '0;
      py_q             <= '0;
      nxt_q            <= '0;
      e_q              <= '0;
      a_q              <= '0;
      res_active_q     <= 1'b0;
      res_frame_q      <= '0;
      res_on_path_q    <= 1'b0;
      res_dropped_q    <= 1'b0;
      out_valid_q      <= 1'b0;
      out_active_q     <= 1'b0;
      out_frame_q      <= '0;
      out_on_path_q    <= 1'b0;
      out_pos_x_q      <= '0;
      out_pos_y_q      <= '0;
      out_dropped_q    <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CfgFrameInterval: frame_interval_q <= cfg_i.data;
          CfgTrackInterval: track_interval_q <= cfg_i.data;
          CfgFrameCount:    frame_count_q    <= cfg_i.data[CountW-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q   <= 1'b1;
        out_active_q  <= res_active_q;
        out_frame_q   <= res_frame_q;
        out_on_path_q <= res_on_path_q;
        out_pos_x_q   <= res_on_path_q ? pos_x : '0;
        out_pos_y_q   <= res_on_path_q ? pos_y : '0;
        out_dropped_q <= res_dropped_q;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            op_q    <= in_i.op;
            now_q   <= in_i.now_ms;
            px_q    <= in_i.point_x;
            py_q    <= in_i.point_y;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_active_q  <= (op_q == OpTick) && tick_live;
          res_on_path_q <= path_live;
          res_dropped_q <= (op_q == OpAddPoint) && table_full;
          res_frame_q   <= (op_q == OpStop) ? '0 :
                           (((op_q == OpTick) && tick_live) ? cf_new : cur_frame_q);
          state_q       <= path_live ? S_RDA : S_OUT;
          unique case (op_q)
            OpTick: begin
              if (tick_live) begin
                cur_frame_q <= cf_new;
                if (frame_due) frame_since_q <= now_q;
                if (point_total_q > TW'(1)) begin
                  cur_point_q <= cp_new;
                  if (point_due) point_since_q <= now_q;
                  nxt_q       <= cp_nxt;
                  e_q         <= e_new;
                end else begin
                  cur_point_q <= cp_base;
                end
              end
            end
            OpStart: begin
              running_q     <= 1'b1;
              frame_since_q <= now_q;
              point_since_q <= now_q;
            end
            OpPause: begin
              running_q <= 1'b0;
            end
            OpStop: begin
              running_q     <= 1'b0;
              cur_frame_q   <= '0;
              cur_point_q   <= '0;
              frame_since_q <= now_q;
              point_since_q <= now_q;
            end
            OpAddPoint: begin
              if (!table_full) begin
                point_total_q <= point_total_q + TW'(1);
                cur_point_q   <= '0;
              end
            end
            OpClearPoints: begin
              point_total_q <= '0;
              cur_point_q   <= '0;
            end
            default: ;
          endcase
        end
        S_RDA: state_q <= S_RDB;
        S_RDB: begin
          a_q     <= rdata_q;
          state_q <= S_RDC;
        end
        S_RDC: state_q <= S_LERP;
        S_LERP: begin
          if (done_x && done_y) state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cfg_i.ready       = 1'b1;
  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.active      = out_active_q;
  assign out_o.frame_index = out_frame_q;
  assign out_o.on_path     = out_on_path_q;
  assign out_o.pos_x       = out_pos_x_q;
  assign out_o.pos_y       = out_pos_y_q;
  assign out_o.dropped     = out_dropped_q;

endmodule

`default_nettype wire
